[hw/rtl/nfde_pkg.sv]
// shared types and constants for the nibble framebuffer draw engine
`default_nettype none
package nfde_pkg;

   // store geometry
   localparam int STORE_DEPTH = 8192;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // panel size after reset
   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;

   // nibble masks
   localparam logic [7:0] LO_NIBBLE = 8'h0F;
   localparam logic [7:0] HI_NIBBLE = 8'hF0;

   // command codes
   localparam logic [2:0] CMD_SET   = 3'd0;
   localparam logic [2:0] CMD_LINE  = 3'd1;
   localparam logic [2:0] CMD_RECT  = 3'd2;
   localparam logic [2:0] CMD_CLEAR = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // datapath operations
   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_LOAD     = 4'd1;
   localparam logic [3:0] OP_INIT     = 4'd2;
   localparam logic [3:0] OP_CLR      = 4'd3;
   localparam logic [3:0] OP_RD       = 4'd4;
   localparam logic [3:0] OP_RD_LATCH = 4'd5;
   localparam logic [3:0] OP_PIX_ADDR = 4'd6;
   localparam logic [3:0] OP_PIX_RD   = 4'd7;
   localparam logic [3:0] OP_PIX_WR   = 4'd8;
   localparam logic [3:0] OP_BOX_INIT = 4'd9;
   localparam logic [3:0] OP_BOX_NEXT = 4'd10;
   localparam logic [3:0] OP_LINE_BOX = 4'd11;
   localparam logic [3:0] OP_LINE_STEP = 4'd12;

   // pixel coordinate sources
   localparam logic [1:0] SRC_REQ  = 2'd0;
   localparam logic [1:0] SRC_BOX  = 2'd1;
   localparam logic [1:0] SRC_LINE = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] src;
   } dp_ctrl_type;

   typedef struct packed {
      logic init_last;
      logic clr_empty;
      logic clr_last;
      logic box_empty;
      logic box_draw;
      logic box_last;
      logic line_brk;
      logic thick_one;
   } dp_stat_type;

endpackage
`default_nettype wire

[hw/rtl/nfde_datapath.sv]
// datapath: frame store, pixel read-modify-write, box, line and clear counters
`default_nettype none
module nfde_datapath #(
   parameter int MAX_WIDTH  = nfde_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = nfde_pkg::MAX_HEIGHT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nfde_pkg::dp_ctrl_type  ctrl,
   output nfde_pkg::dp_stat_type       stat,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_index,
   input  wire logic [7:0]             csr_wdata,
   input  wire logic [7:0]             req_x_a,
   input  wire logic [7:0]             req_y_a,
   input  wire logic [7:0]             req_x_b,
   input  wire logic [7:0]             req_y_b,
   input  wire logic [3:0]             req_thickness,
   input  wire logic [3:0]             req_colour,
   input  wire logic                   req_fill,
   input  wire logic [12:0]            req_read_addr,
   output logic [7:0]                  rsp_read_data
);
   localparam int AW = nfde_pkg::ADDR_W;

   // configuration registers
   logic [7:0] width_ff, height_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'(MAX_WIDTH);
         height_ff <= 8'(MAX_HEIGHT);
      end else if (csr_wr_en) begin
         if (csr_index == nfde_pkg::CSR_WIDTH) width_ff <= csr_wdata;
         else height_ff <= csr_wdata;
      end
   end

   logic [6:0] half;
   assign half = width_ff[7:1];

   // latched transaction fields
   logic [7:0]    xa_ff, ya_ff;
   logic [3:0]    thick_ff, colour_ff;
   logic [AW-1:0] raddr_ff;
   logic [7:0]    resp_ff;

   // box walker
   logic [8:0] bxa_ff, bxb_ff, bya_ff, byb_ff, bx_ff, by_ff;
   logic       solid_ff;

   // line walker
   logic [7:0]        lx_ff, ly_ff, lx2_ff, ly2_ff;
   logic              sxp_ff, syp_ff;
   logic signed [11:0] dx_ff, dy_ff, err_ff;

   // clear and init sweep
   logic [6:0]    col_ff;
   logic [7:0]    row_ff;
   logic [AW-1:0] sweep_ff;

   // pixel pipeline
   logic [AW-1:0] paddr_ff;
   logic          podd_ff, pvalid_ff;

   // frame store
   logic [7:0]    mem [nfde_pkg::STORE_DEPTH];
   logic [7:0]    q_ff;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata;

   // line step arithmetic
   logic signed [11:0] e2, err1, err2, e2b;
   logic               c1, c2;
   logic [7:0]         x1, y1;
   always_comb begin
      e2   = err_ff <<< 1;
      c1   = (e2 >= dy_ff);
      err1 = c1 ? err_ff + dy_ff : err_ff;
      x1   = c1 ? (sxp_ff ? lx_ff + 8'd1 : lx_ff - 8'd1) : lx_ff;
      e2b  = err1 <<< 1;
      c2   = (e2b <= dx_ff);
      err2 = c2 ? err1 + dx_ff : err1;
      y1   = c2 ? (syp_ff ? ly_ff + 8'd1 : ly_ff - 8'd1) : ly_ff;
   end

   // pixel coordinate select and address
   logic [8:0]  px, py;
   logic [15:0] prod;
   always_comb begin
      unique case (ctrl.src)
         nfde_pkg::SRC_BOX:  begin px = bx_ff; py = by_ff; end
         nfde_pkg::SRC_LINE: begin px = {1'b0, lx_ff}; py = {1'b0, ly_ff}; end
         default:            begin px = {1'b0, xa_ff}; py = {1'b0, ya_ff}; end
      endcase
      prod = {7'd0, py} * {9'd0, half};
   end

   // line start values from the request
   logic [7:0] adx, ady;
   assign adx = (req_x_b >= req_x_a) ? req_x_b - req_x_a : req_x_a - req_x_b;
   assign ady = (req_y_b >= req_y_a) ? req_y_b - req_y_a : req_y_a - req_y_b;

   // store port select
   always_comb begin
      we    = 1'b0;
      waddr = sweep_ff;
      wdata = 8'd0;
      raddr = paddr_ff;
      unique case (ctrl.op)
         nfde_pkg::OP_INIT: we = 1'b1;
         nfde_pkg::OP_CLR: begin
            we    = 1'b1;
            wdata = {colour_ff, colour_ff};
         end
         nfde_pkg::OP_RD: raddr = raddr_ff;
         nfde_pkg::OP_PIX_WR: begin
            we    = pvalid_ff;
            waddr = paddr_ff;
            wdata = podd_ff ? ((q_ff & nfde_pkg::HI_NIBBLE) | {4'd0, colour_ff})
                            : ((q_ff & nfde_pkg::LO_NIBBLE) | {colour_ff, 4'd0});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      q_ff <= mem[raddr];
   end

   // sweep counter, reset starts the zeroing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (ctrl.op == nfde_pkg::OP_INIT || ctrl.op == nfde_pkg::OP_CLR) begin
         sweep_ff <= sweep_ff + AW'(1);
      end else if (ctrl.op == nfde_pkg::OP_LOAD) begin
         sweep_ff <= '0;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         nfde_pkg::OP_LOAD: begin
            xa_ff     <= req_x_a;
            ya_ff     <= req_y_a;
            thick_ff  <= req_thickness;
            colour_ff <= req_colour;
            raddr_ff  <= req_read_addr[AW-1:0];
            resp_ff   <= 8'd0;
            bxa_ff    <= {1'b0, req_x_a};
            bxb_ff    <= {1'b0, req_x_b};
            bya_ff    <= {1'b0, req_y_a};
            byb_ff    <= {1'b0, req_y_b};
            solid_ff  <= req_fill;
            lx_ff     <= req_x_a;
            ly_ff     <= req_y_a;
            lx2_ff    <= req_x_b;
            ly2_ff    <= req_y_b;
            sxp_ff    <= req_x_a < req_x_b;
            syp_ff    <= req_y_a < req_y_b;
            dx_ff     <= 12'(adx);
            dy_ff     <= -12'(ady);
            err_ff    <= 12'(adx) - 12'(ady);
            col_ff    <= '0;
            row_ff    <= '0;
         end
         nfde_pkg::OP_RD_LATCH: resp_ff <= q_ff;
         nfde_pkg::OP_CLR: begin
            if (col_ff == half - 7'd1) begin
               col_ff <= '0;
               row_ff <= row_ff + 8'd1;
            end else begin
               col_ff <= col_ff + 7'd1;
            end
         end
         nfde_pkg::OP_PIX_ADDR: begin
            paddr_ff  <= AW'(prod + {8'd0, px[8:1]});
            podd_ff   <= px[0];
            pvalid_ff <= (px < {1'b0, width_ff}) && (py < {1'b0, height_ff});
         end
         nfde_pkg::OP_BOX_INIT: begin
            bx_ff <= bxa_ff;
            by_ff <= bya_ff;
         end
         nfde_pkg::OP_BOX_NEXT: begin
            if (bx_ff == bxb_ff - 9'd1) begin
               bx_ff <= bxa_ff;
               by_ff <= by_ff + 9'd1;
            end else begin
               bx_ff <= bx_ff + 9'd1;
            end
         end
         nfde_pkg::OP_LINE_BOX: begin
            bxa_ff   <= {1'b0, lx_ff};
            bxb_ff   <= {1'b0, lx_ff} + {5'd0, thick_ff};
            bya_ff   <= {1'b0, ly_ff};
            byb_ff   <= {1'b0, ly_ff} + {5'd0, thick_ff};
            solid_ff <= 1'b1;
         end
         nfde_pkg::OP_LINE_STEP: begin
            lx_ff  <= x1;
            ly_ff  <= y1;
            err_ff <= err2;
         end
         default: ;
      endcase
   end

   // status back to the controller
   always_comb begin
      stat.init_last = (sweep_ff == AW'(nfde_pkg::STORE_DEPTH - 1));
      stat.clr_empty = (half == 7'd0) || (height_ff == 8'd0);
      stat.clr_last  = (col_ff == half - 7'd1) && (row_ff == height_ff - 8'd1);
      stat.box_empty = (bxa_ff >= bxb_ff) || (bya_ff >= byb_ff);
      stat.box_draw  = solid_ff || bx_ff == bxa_ff || bx_ff == bxb_ff - 9'd1
                       || by_ff == bya_ff || by_ff == byb_ff - 9'd1;
      stat.box_last  = (bx_ff == bxb_ff - 9'd1) && (by_ff == byb_ff - 9'd1);
      stat.line_brk  = (c1 && lx_ff == lx2_ff) || (c2 && ly_ff == ly2_ff);
      stat.thick_one = (thick_ff == 4'd1);
   end

   assign rsp_read_data = resp_ff;

endmodule
`default_nettype wire

[hw/rtl/nfde_ctrl.sv]
// controller: sequences each transaction over the datapath
`default_nettype none
module nfde_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [2:0]            req_cmd,
   input  wire logic [3:0]            req_thickness,
   input  wire nfde_pkg::dp_stat_type stat,
   output nfde_pkg::dp_ctrl_type      ctrl,
   output logic                       busy,
   output logic                       rsp_strobe
);
   localparam logic [3:0] ST_INIT     = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_P_ADDR   = 4'd2;
   localparam logic [3:0] ST_P_RD     = 4'd3;
   localparam logic [3:0] ST_P_WR     = 4'd4;
   localparam logic [3:0] ST_BOX_INIT = 4'd5;
   localparam logic [3:0] ST_BOX_PIX  = 4'd6;
   localparam logic [3:0] ST_BOX_NEXT = 4'd7;
   localparam logic [3:0] ST_LINE_PT  = 4'd8;
   localparam logic [3:0] ST_LINE_STEP = 4'd9;
   localparam logic [3:0] ST_CLR_INIT = 4'd10;
   localparam logic [3:0] ST_CLR      = 4'd11;
   localparam logic [3:0] ST_RD       = 4'd12;
   localparam logic [3:0] ST_RD_LATCH = 4'd13;
   localparam logic [3:0] ST_RESP     = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [1:0] src_ff, src_in;
   logic       is_line_ff, is_line_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         src_ff     <= nfde_pkg::SRC_REQ;
         is_line_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         src_ff     <= src_in;
         is_line_ff <= is_line_in;
      end
   end

   // next state and datapath command
   always_comb begin
      state_in   = state_ff;
      src_in     = src_ff;
      is_line_in = is_line_ff;
      ctrl.op    = nfde_pkg::OP_NONE;
      ctrl.src   = src_ff;
      unique case (state_ff)
         ST_INIT: begin
            ctrl.op = nfde_pkg::OP_INIT;
            if (stat.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               ctrl.op    = nfde_pkg::OP_LOAD;
               is_line_in = (req_cmd == nfde_pkg::CMD_LINE);
               src_in     = nfde_pkg::SRC_REQ;
               priority case (req_cmd)
                  nfde_pkg::CMD_SET:   state_in = ST_P_ADDR;
                  nfde_pkg::CMD_LINE:
                     state_in = (req_thickness == 4'd0) ? ST_RESP : ST_LINE_PT;
                  nfde_pkg::CMD_RECT:  state_in = ST_BOX_INIT;
                  nfde_pkg::CMD_CLEAR: state_in = ST_CLR_INIT;
                  nfde_pkg::CMD_READ:  state_in = ST_RD;
                  default:             state_in = ST_RESP;
               endcase
            end
         end
         ST_P_ADDR: begin
            ctrl.op  = nfde_pkg::OP_PIX_ADDR;
            state_in = ST_P_RD;
         end
         ST_P_RD: begin
            ctrl.op  = nfde_pkg::OP_PIX_RD;
            state_in = ST_P_WR;
         end
         ST_P_WR: begin
            ctrl.op = nfde_pkg::OP_PIX_WR;
            unique case (src_ff)
               nfde_pkg::SRC_BOX:  state_in = ST_BOX_NEXT;
               nfde_pkg::SRC_LINE: state_in = ST_LINE_STEP;
               default:            state_in = ST_RESP;
            endcase
         end
         ST_BOX_INIT: begin
            ctrl.op = nfde_pkg::OP_BOX_INIT;
            if (stat.box_empty) state_in = is_line_ff ? ST_LINE_STEP : ST_RESP;
            else state_in = ST_BOX_PIX;
         end
         ST_BOX_PIX: begin
            src_in = nfde_pkg::SRC_BOX;
            state_in = stat.box_draw ? ST_P_ADDR : ST_BOX_NEXT;
         end
         ST_BOX_NEXT: begin
            ctrl.op = nfde_pkg::OP_BOX_NEXT;
            if (stat.box_last) state_in = is_line_ff ? ST_LINE_STEP : ST_RESP;
            else state_in = ST_BOX_PIX;
         end
         ST_LINE_PT: begin
            if (stat.thick_one) begin
               src_in   = nfde_pkg::SRC_LINE;
               state_in = ST_P_ADDR;
            end else begin
               ctrl.op  = nfde_pkg::OP_LINE_BOX;
               state_in = ST_BOX_INIT;
            end
         end
         ST_LINE_STEP: begin
            ctrl.op  = nfde_pkg::OP_LINE_STEP;
            state_in = stat.line_brk ? ST_RESP : ST_LINE_PT;
         end
         ST_CLR_INIT: state_in = stat.clr_empty ? ST_RESP : ST_CLR;
         ST_CLR: begin
            ctrl.op = nfde_pkg::OP_CLR;
            if (stat.clr_last) state_in = ST_RESP;
         end
         ST_RD: begin
            ctrl.op  = nfde_pkg::OP_RD;
            state_in = ST_RD_LATCH;
         end
         ST_RD_LATCH: begin
            ctrl.op  = nfde_pkg::OP_RD_LATCH;
            state_in = ST_RESP;
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

endmodule
`default_nettype wire

[hw/rtl/nibble_framebuffer_draw_engine_unit.sv]
// top level of the nibble framebuffer draw engine
// A transaction is taken when start is high and busy is low; busy stays high until its
// single result has been shown on rsp_read_data for one cycle with rsp_strobe. The result
// cannot be held off: the receiver must take it in the cycle rsp_strobe is high. After reset
// the block zeroes its 8192-byte store, one byte a cycle, and busy stays high until it is done.
// Every pixel is a read-modify-write of one store byte, through the address, read and write
// states. A set pixel writes one pixel and a read latches one store byte; an unknown command or
// zero-thickness line draws nothing, clear fills height*(width/2) bytes, a rectangle visits
// every cell and writes the drawn ones, a thin line writes one pixel per point, and a thick
// line a solid thickness*thickness square per point.
`default_nettype none
module nibble_framebuffer_draw_engine_unit #(
   parameter int MAX_WIDTH  = nfde_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = nfde_pkg::MAX_HEIGHT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [7:0]  req_x_a,
   input  wire logic [7:0]  req_y_a,
   input  wire logic [7:0]  req_x_b,
   input  wire logic [7:0]  req_y_b,
   input  wire logic [3:0]  req_thickness,
   input  wire logic [3:0]  req_colour,
   input  wire logic        req_fill,
   input  wire logic [12:0] req_read_addr,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_read_data,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);
   nfde_pkg::dp_ctrl_type ctrl;
   nfde_pkg::dp_stat_type stat;

   // controller
   nfde_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_cmd       (req_cmd),
      .req_thickness (req_thickness),
      .stat          (stat),
      .ctrl          (ctrl),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe)
   );

   // datapath
   nfde_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_x_a       (req_x_a),
      .req_y_a       (req_y_a),
      .req_x_b       (req_x_b),
      .req_y_b       (req_y_b),
      .req_thickness (req_thickness),
      .req_colour    (req_colour),
      .req_fill      (req_fill),
      .req_read_addr (req_read_addr),
      .rsp_read_data (rsp_read_data)
   );

   // a result only comes while a transaction is open
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result outside a transaction");

   // an accepted transaction keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised on accept");

   // one result per transaction, then the block frees
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy)) else $error("result repeated");

endmodule
`default_nettype wire

[test/nibble_framebuffer_draw_engine_unit_tb.sv]
// self-checking testbench for the nibble framebuffer draw engine
`timescale 1ns / 1ps
`default_nettype none
module nibble_framebuffer_draw_engine_unit_tb;

   // command code with no operation behind it
   localparam logic [2:0] CMD_SPARE = 3'd7;

   typedef struct {
      logic [2:0]  cmd;
      logic [7:0]  xa, ya, xb, yb;
      logic [3:0]  thick, colour;
      logic        fill;
      logic [12:0] raddr;
   } draw_cmd_type;

   // scoreboard: shadow framebuffer plus queue of expected read bytes
   class frame_scoreboard;
      logic [7:0] pixels[nfde_pkg::STORE_DEPTH];
      int unsigned width, height;
      logic [7:0] pending[$];

      function void init();
         foreach (pixels[i]) pixels[i] = 8'h00;
         width  = nfde_pkg::MAX_WIDTH;
         height = nfde_pkg::MAX_HEIGHT;
         pending.delete();
      endfunction

      function void plot(int unsigned x, int unsigned y, logic [3:0] c);
         int unsigned a;
         if (x >= width || y >= height) return;
         a = ((x >> 1) + y * (width >> 1)) % nfde_pkg::STORE_DEPTH;
         if (x[0] == 1'b0) pixels[a] = {c, pixels[a][3:0]};
         else pixels[a] = {pixels[a][7:4], c};
      endfunction

      function void box(int unsigned xa, int unsigned ya, int unsigned xb, int unsigned yb,
                        logic [3:0] c, bit solid);
         for (int unsigned y = ya; y < yb; y++)
            for (int unsigned x = xa; x < xb; x++)
               if (solid || x == xa || x == xb - 1 || y == ya || y == yb - 1)
                  plot(x, y, c);
      endfunction

      // bresenham walk, squares at each point for thick lines
      function void segment(int xa, int ya, int xb, int yb, int unsigned sz, logic [3:0] c);
         int x, y, dx, dy, sx, sy, err;
         bit done;
         x = xa; y = ya;
         dx = (xb >= x) ? xb - x : x - xb;
         dy = (yb >= y) ? y - yb : yb - y;
         sx = (x < xb) ? 1 : -1;
         sy = (y < yb) ? 1 : -1;
         err = dx + dy;
         done = 0;
         while (!done) begin
            if (sz == 1) plot(x, y, c);
            else box(x, y, x + sz, y + sz, c, 1'b1);
            if (2 * err >= dy) begin
               if (x == xb) done = 1;
               else begin
                  err += dy;
                  x += sx;
               end
            end
            if (!done && 2 * err <= dx) begin
               if (y == yb) done = 1;
               else begin
                  err += dx;
                  y += sy;
               end
            end
         end
      endfunction

      // note an accepted transaction: update the shadow frame, queue its result
      function void note_request(draw_cmd_type t);
         logic [7:0] rd;
         int unsigned half;
         rd = 8'h00;
         half = width >> 1;
         case (t.cmd)
            nfde_pkg::CMD_SET:   plot(t.xa, t.ya, t.colour);
            nfde_pkg::CMD_LINE:
               if (t.thick != 0) segment(t.xa, t.ya, t.xb, t.yb, t.thick, t.colour);
            nfde_pkg::CMD_RECT:  box(t.xa, t.ya, t.xb, t.yb, t.colour, t.fill);
            nfde_pkg::CMD_CLEAR: begin
               for (int unsigned r = 0; r < height; r++)
                  for (int unsigned col = 0; col < half; col++)
                     pixels[(r * half + col) % nfde_pkg::STORE_DEPTH] = {t.colour, t.colour};
            end
            nfde_pkg::CMD_READ:  rd = pixels[t.raddr];
            default: ;
         endcase
         pending.push_back(rd);
      endfunction

      function bit check_result(logic [7:0] got, output string why);
         logic [7:0] want;
         if (pending.size() == 0) begin
            why = $sformatf("unexpected result %02h", got);
            return 0;
         end
         want = pending.pop_front();
         why = $sformatf("read_data %02h, expected %02h", got, want);
         return got === want;
      endfunction
   endclass

   logic        clock, reset, start, busy;
   logic [2:0]  req_cmd;
   logic [7:0]  req_x_a, req_y_a, req_x_b, req_y_b;
   logic [3:0]  req_thickness, req_colour;
   logic        req_fill;
   logic [12:0] req_read_addr;
   logic        rsp_strobe;
   logic [7:0]  rsp_read_data;
   logic        csr_wr_en, csr_index;
   logic [7:0]  csr_wdata;

   frame_scoreboard sb;
   int errors = 0;

   nibble_framebuffer_draw_engine_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_x_a(req_x_a), .req_y_a(req_y_a),
      .req_x_b(req_x_b), .req_y_b(req_y_b), .req_thickness(req_thickness),
      .req_colour(req_colour), .req_fill(req_fill), .req_read_addr(req_read_addr),
      .rsp_strobe(rsp_strobe), .rsp_read_data(rsp_read_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   task automatic report_mismatch(string msg);
      errors++;
      $display("%0t mismatch: %s", $realtime, msg);
   endtask

   // result monitor
   always @(posedge clock) begin
      string why;
      if (!reset && rsp_strobe)
         if (!sb.check_result(rsp_read_data, why)) report_mismatch(why);
   end

   // present one transaction from a falling edge until it is taken; start stays high
   task automatic send(draw_cmd_type t);
      req_cmd <= t.cmd; req_x_a <= t.xa; req_y_a <= t.ya; req_x_b <= t.xb;
      req_y_b <= t.yb; req_thickness <= t.thick; req_colour <= t.colour;
      req_fill <= t.fill; req_read_addr <= t.raddr;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(t);
      @(negedge clock);
   endtask

   // lower start and wait for every outstanding result, then a short settle
   task automatic drain();
      int n;
      start <= 1'b0;
      n = 0;
      while (sb.pending.size() != 0 && n < 400000) begin
         @(negedge clock);
         n++;
      end
      if (sb.pending.size() != 0) report_mismatch("results missing at drain");
      repeat (20) @(negedge clock);
   endtask

   task automatic set_panel(int unsigned w, int unsigned h);
      csr_wr_en <= 1'b1; csr_index <= nfde_pkg::CSR_WIDTH; csr_wdata <= w[7:0];
      @(negedge clock);
      csr_index <= nfde_pkg::CSR_HEIGHT; csr_wdata <= h[7:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.width = w;
      sb.height = h;
      @(negedge clock);
   endtask

   function automatic logic [7:0] clip(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   function automatic logic [7:0] coord(int unsigned lim);
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return clip($urandom_range(0, lim + 2));
   endfunction

   // random transaction, kept mostly small so the run stays short
   function automatic draw_cmd_type random_cmd();
      draw_cmd_type t;
      int unsigned r, span, words;
      t.cmd = 3'($urandom); t.xa = 8'($urandom); t.ya = 8'($urandom);
      t.xb = 8'($urandom); t.yb = 8'($urandom);
      t.thick = 4'($urandom); t.colour = 4'($urandom); t.fill = 1'($urandom);
      t.raddr = 13'($urandom);
      r = $urandom_range(0, 99);
      if (r < 25) begin
         t.cmd = nfde_pkg::CMD_SET;
         t.xa = coord(sb.width); t.ya = coord(sb.height);
      end else if (r < 45) begin
         t.cmd = nfde_pkg::CMD_LINE;
         t.xa = coord(sb.width); t.ya = coord(sb.height);
         r = $urandom_range(0, 9);
         if (r < 6) t.thick = 4'd1;
         else if (r == 6) t.thick = 4'd0;
         else if (r < 9) t.thick = 4'($urandom_range(2, 4));
         else t.thick = 4'($urandom_range(5, 15));
         span = (t.thick == 1) ? 255 : (t.thick <= 4 ? 20 : 5);
         if (t.thick == 1) begin
            t.xb = coord(sb.width); t.yb = coord(sb.height);
         end else begin
            t.xb = clip(int'(t.xa) + int'($urandom_range(0, 2 * span)) - int'(span));
            t.yb = clip(int'(t.ya) + int'($urandom_range(0, 2 * span)) - int'(span));
         end
      end else if (r < 65) begin
         t.cmd = nfde_pkg::CMD_RECT;
         t.xa = coord(sb.width); t.ya = coord(sb.height);
         if ($urandom_range(0, 49) == 0) begin
            t.xb = 8'($urandom); t.yb = 8'($urandom);
         end else begin
            t.xb = clip(int'(t.xa) + int'($urandom_range(0, 18)) - 2);
            t.yb = clip(int'(t.ya) + int'($urandom_range(0, 18)) - 2);
         end
      end else if (r < 67) begin
         t.cmd = nfde_pkg::CMD_CLEAR;
      end else if (r < 95) begin
         t.cmd = nfde_pkg::CMD_READ;
         words = (sb.width >> 1) * sb.height;
         if (words != 0 && $urandom_range(0, 6) != 0)
            t.raddr = 13'($urandom_range(0, (words > nfde_pkg::STORE_DEPTH ?
                                             nfde_pkg::STORE_DEPTH : words) - 1));
      end else begin
         t.cmd = 3'($urandom_range(5, 7));
      end
      return t;
   endfunction

   function automatic draw_cmd_type mk(logic [2:0] c, int xa, int ya, int xb, int yb,
                                       int th, int col, bit f, int ra);
      draw_cmd_type t;
      t.cmd = c; t.xa = 8'(xa); t.ya = 8'(ya); t.xb = 8'(xb); t.yb = 8'(yb);
      t.thick = 4'(th); t.colour = 4'(col); t.fill = f; t.raddr = 13'(ra);
      return t;
   endfunction

   task automatic random_phase(int unsigned count);
      int unsigned done, burst;
      done = 0;
      while (done < count) begin
         burst = $urandom_range(1, 12);
         for (int unsigned i = 0; i < burst && done < count; i++) begin
            send(random_cmd());
            done++;
         end
         if ($urandom_range(0, 29) == 0) drain();
         else if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   initial begin
      int unsigned widths[6]  = '{128, 2, 17, 40, 255, 128};
      int unsigned heights[6] = '{128, 1, 9, 30, 255, 64};
      int unsigned counts[6]  = '{600, 200, 300, 400, 100, 330};
      draw_cmd_type directed[$];
      sb = new();
      sb.init();
      reset = 1'b1; start = 1'b0;
      req_cmd = '0; req_x_a = '0; req_y_a = '0; req_x_b = '0; req_y_b = '0;
      req_thickness = '0; req_colour = '0; req_fill = 1'b0; req_read_addr = '0;
      csr_wr_en = 1'b0; csr_index = nfde_pkg::CSR_WIDTH; csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners, dropped pixels, empty shapes, thick and zero-thickness lines
      directed = '{
         mk(nfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(nfde_pkg::CMD_SET, 0, 0, 0, 0, 0, 15, 0, 0),
         mk(nfde_pkg::CMD_SET, 1, 0, 0, 0, 0, 10, 0, 0),
         mk(nfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(nfde_pkg::CMD_SET, 127, 127, 0, 0, 0, 5, 0, 0),
         mk(nfde_pkg::CMD_SET, 128, 3, 0, 0, 0, 7, 0, 0),
         mk(nfde_pkg::CMD_SET, 3, 128, 0, 0, 0, 7, 0, 0),
         mk(nfde_pkg::CMD_SET, 255, 255, 255, 255, 15, 15, 1, 8191),
         mk(nfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 8191),
         mk(nfde_pkg::CMD_LINE, 0, 0, 20, 7, 0, 9, 0, 0),
         mk(nfde_pkg::CMD_LINE, 0, 0, 20, 7, 1, 9, 0, 0),
         mk(nfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 64),
         mk(nfde_pkg::CMD_LINE, 126, 120, 122, 126, 15, 3, 0, 0),
         mk(nfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 8191),
         mk(nfde_pkg::CMD_RECT, 10, 10, 10, 20, 0, 4, 1, 0),
         mk(nfde_pkg::CMD_RECT, 10, 10, 20, 15, 0, 6, 0, 0),
         mk(nfde_pkg::CMD_RECT, 120, 120, 255, 255, 0, 2, 1, 0),
         mk(nfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 10 * 64 + 5),
         mk(nfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 12 * 64 + 6),
         mk(CMD_SPARE, 5, 5, 9, 9, 1, 15, 1, 0),
         mk(nfde_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 12, 0, 0),
         mk(nfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 4095)
      };
      foreach (directed[i]) send(directed[i]);
      drain();

      for (int p = 0; p < 6; p++) begin
         set_panel(widths[p], heights[p]);
         random_phase(counts[p]);
         drain();
      end

      repeat (50) @(negedge clock);
      if (errors == 0) $display("nibble_framebuffer_draw_engine_unit_tb: PASS");
      else $display("nibble_framebuffer_draw_engine_unit_tb: FAIL");
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #200_000_000;
      $display("nibble_framebuffer_draw_engine_unit_tb: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
